// ----- src/eia_pkg.sv -----
`timescale 1ns / 1ps
package eia_pkg;
  localparam int unsigned IdBits = 10;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned CntBits = 11;
  localparam int unsigned RecBits = 16;
  localparam int unsigned KindBits = 3;
  localparam int unsigned StatBits = 3;

  typedef enum logic [KindBits-1:0] {
    K_ALLOC = 3'd0, K_ALLOC_AT = 3'd1, K_RELEASE = 3'd2, K_BIND = 3'd3, K_READ = 3'd4,
    K_NONE = 3'd7
  } kind_e;

  typedef enum logic [StatBits-1:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_RANGE = 3'd2, ST_IGNORED = 3'd3, ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_POP_RD, S_POP_WAIT, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_RD,
    S_SHIFT_WR, S_CLAIM, S_REC_RD, S_REC_WAIT, S_DONE, S_CLEAR
  } state_e;

  typedef struct packed {
    logic latch;
    logic pop_rd;
    logic pop_take;
    logic fresh_take;
    logic scan_rd;
    logic scan_next;
    logic shift_rd;
    logic shift_wr;
    logic claim;
    logic release_do;
    logic bind_do;
    logic rec_rd;
    logic rec_take;
    logic set_full;
    logic set_ignored;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  stack_empty;
    logic  hw_full;
    logic  scan_end;
    logic  scan_hit;
    logic  shift_end;
    logic  is_live;
    logic  clear_end;
  } stat_t;
endpackage

// ----- src/eia_stream_if.sv -----
`timescale 1ns / 1ps
interface eia_in_if;
  logic valid;
  logic ready;
  logic [2:0] kind;
  logic [9:0] ident;
  logic [15:0] slot_index;
  modport source (output valid, kind, ident, slot_index, input ready);
  modport sink (input valid, kind, ident, slot_index, output ready);
endinterface

interface eia_out_if;
  logic valid;
  logic ready;
  logic [9:0] result_id;
  logic [2:0] status;
  logic [15:0] record_value;
  modport source (output valid, result_id, status, record_value, input ready);
  modport sink (input valid, result_id, status, record_value, output ready);
endinterface

// ----- src/eia_ram.sv -----
`timescale 1ns / 1ps
module eia_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/eia_ctrl.sv -----
`timescale 1ns / 1ps
module eia_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_valid_i,
  input  eia_pkg::stat_t  stat_i,
  output eia_pkg::cmd_t   cmd_o
);
  eia_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eia_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eia_pkg::S_CLEAR: if (stat_i.clear_end) state_d = eia_pkg::S_IDLE;
      eia_pkg::S_IDLE: if (in_valid_i && !out_valid_i) state_d = eia_pkg::S_DECODE;
      eia_pkg::S_DECODE: begin
        priority case (stat_i.kind)
          eia_pkg::K_ALLOC: begin
            if (!stat_i.stack_empty) state_d = eia_pkg::S_POP_RD;
            else state_d = eia_pkg::S_DONE;
          end
          eia_pkg::K_ALLOC_AT: state_d = eia_pkg::S_SCAN_RD;
          eia_pkg::K_READ: state_d = eia_pkg::S_REC_RD;
          default: state_d = eia_pkg::S_DONE;
        endcase
      end
      eia_pkg::S_POP_RD: state_d = eia_pkg::S_POP_WAIT;
      eia_pkg::S_POP_WAIT: state_d = eia_pkg::S_DONE;
      eia_pkg::S_SCAN_RD: begin
        if (stat_i.scan_end) state_d = eia_pkg::S_CLAIM;
        else state_d = eia_pkg::S_SCAN_CHK;
      end
      eia_pkg::S_SCAN_CHK: begin
        if (stat_i.scan_hit) state_d = eia_pkg::S_SHIFT_RD;
        else state_d = eia_pkg::S_SCAN_RD;
      end
      eia_pkg::S_SHIFT_RD: begin
        if (stat_i.shift_end) state_d = eia_pkg::S_CLAIM;
        else state_d = eia_pkg::S_SHIFT_WR;
      end
      eia_pkg::S_SHIFT_WR: state_d = eia_pkg::S_SHIFT_RD;
      eia_pkg::S_CLAIM: state_d = eia_pkg::S_DONE;
      eia_pkg::S_REC_RD: state_d = eia_pkg::S_REC_WAIT;
      eia_pkg::S_REC_WAIT: state_d = eia_pkg::S_DONE;
      eia_pkg::S_DONE: state_d = eia_pkg::S_IDLE;
      default: state_d = eia_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == eia_pkg::S_IDLE) && !out_valid_i;
    unique case (state_q)
      eia_pkg::S_CLEAR: cmd_o.clear = 1'b1;
      eia_pkg::S_IDLE: cmd_o.latch = in_valid_i && !out_valid_i;
      eia_pkg::S_DECODE: begin
        if (stat_i.kind == eia_pkg::K_ALLOC) begin
          if (stat_i.stack_empty && !stat_i.hw_full) cmd_o.fresh_take = 1'b1;
          if (stat_i.stack_empty && stat_i.hw_full) cmd_o.set_full = 1'b1;
        end
        if (stat_i.kind == eia_pkg::K_RELEASE) begin
          if (stat_i.is_live) cmd_o.release_do = 1'b1;
          else cmd_o.set_ignored = 1'b1;
        end
        if (stat_i.kind == eia_pkg::K_BIND) cmd_o.bind_do = 1'b1;
      end
      eia_pkg::S_POP_RD: cmd_o.pop_rd = 1'b1;
      eia_pkg::S_POP_WAIT: cmd_o.pop_take = 1'b1;
      eia_pkg::S_SCAN_RD: cmd_o.scan_rd = 1'b1;
      eia_pkg::S_SCAN_CHK: cmd_o.scan_next = 1'b1;
      eia_pkg::S_SHIFT_RD: cmd_o.shift_rd = 1'b1;
      eia_pkg::S_SHIFT_WR: cmd_o.shift_wr = 1'b1;
      eia_pkg::S_CLAIM: cmd_o.claim = 1'b1;
      eia_pkg::S_REC_RD: cmd_o.rec_rd = 1'b1;
      eia_pkg::S_REC_WAIT: cmd_o.rec_take = 1'b1;
      eia_pkg::S_DONE: cmd_o.out_load = 1'b1;
      default: ;
    endcase
  end

  a_load_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !out_valid_i) else $error("result overwrite");
  a_latch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> state_q == eia_pkg::S_DECODE) else $error("latch lost");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == eia_pkg::S_DONE |=> state_q == eia_pkg::S_IDLE) else $error("done stuck");
endmodule

// ----- src/eia_datapath.sv -----
`timescale 1ns / 1ps
module eia_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [eia_pkg::KindBits-1:0]      kind_i,
  input  logic [eia_pkg::IdBits-1:0]        ident_i,
  input  logic [eia_pkg::RecBits-1:0]       slot_index_i,
  input  eia_pkg::cmd_t                     cmd_i,
  output eia_pkg::stat_t                    stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [eia_pkg::IdBits-1:0]        result_id_o,
  output logic [eia_pkg::StatBits-1:0]      status_o,
  output logic [eia_pkg::RecBits-1:0]       record_value_o
);
  logic [eia_pkg::KindBits-1:0] kind_q;
  logic [eia_pkg::IdBits-1:0]   id_q;
  logic [eia_pkg::RecBits-1:0]  val_q;
  logic [eia_pkg::CntBits-1:0]  hw_q, depth_q, idx_q;
  logic [eia_pkg::IdBits-1:0]   rid_q;
  logic [eia_pkg::RecBits-1:0]  rec_q;
  eia_pkg::status_e             st_q;
  logic                         out_valid_q;

  logic                         fs_we;
  logic [eia_pkg::IdBits-1:0]   fs_waddr, fs_wdata, fs_raddr, fs_rdata;
  logic                         lv_we, lv_wdata, lv_rdata;
  logic [eia_pkg::IdBits-1:0]   lv_waddr, lv_raddr;
  logic                         rs_we;
  logic [eia_pkg::IdBits-1:0]   rs_waddr;
  logic [eia_pkg::RecBits:0]    rs_wdata, rs_rdata;
  logic [eia_pkg::CntBits-1:0]  id_ext, depth_m1;
  logic                         in_range;

  assign id_ext = {1'b0, id_q};
  assign depth_m1 = depth_q - 1'b1;
  assign in_range = id_ext < eia_pkg::CntBits'(eia_pkg::Capacity);

  always_comb begin
    fs_we = 1'b0;
    fs_waddr = depth_q[eia_pkg::IdBits-1:0];
    fs_wdata = id_q;
    fs_raddr = idx_q[eia_pkg::IdBits-1:0];
    if (cmd_i.release_do && in_range && depth_q < eia_pkg::CntBits'(eia_pkg::Capacity)) begin
      fs_we = 1'b1;
    end
    if (cmd_i.pop_rd) fs_raddr = depth_m1[eia_pkg::IdBits-1:0];
    if (cmd_i.shift_rd) fs_raddr = idx_q[eia_pkg::IdBits-1:0] + 1'b1;
    if (cmd_i.shift_wr) begin
      fs_we = 1'b1;
      fs_waddr = idx_q[eia_pkg::IdBits-1:0];
      fs_wdata = fs_rdata;
    end
  end

  // live marks, cleared by the pass after reset
  always_comb begin
    lv_we = cmd_i.pop_take || cmd_i.fresh_take || cmd_i.claim || cmd_i.release_do ||
            cmd_i.clear;
    lv_wdata = cmd_i.pop_take || cmd_i.fresh_take || cmd_i.claim;
    lv_waddr = id_q;
    if (cmd_i.pop_take) lv_waddr = fs_rdata;
    if (cmd_i.fresh_take) lv_waddr = hw_q[eia_pkg::IdBits-1:0];
    if (cmd_i.clear) lv_waddr = idx_q[eia_pkg::IdBits-1:0];
    lv_raddr = cmd_i.latch ? ident_i : id_q;
  end

  // record table, top bit marks a stored record
  always_comb begin
    rs_we = cmd_i.bind_do || cmd_i.release_do || cmd_i.clear;
    rs_waddr = cmd_i.clear ? idx_q[eia_pkg::IdBits-1:0] : id_q;
    rs_wdata = cmd_i.bind_do ? {1'b1, val_q} : '0;
  end

  eia_ram #(.Width(eia_pkg::IdBits), .Depth(eia_pkg::Capacity)) u_free (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );

  eia_ram #(.Width(1), .Depth(eia_pkg::Capacity)) u_live (
    .clk_i, .we_i(lv_we), .waddr_i(lv_waddr), .wdata_i(lv_wdata),
    .raddr_i(lv_raddr), .rdata_o(lv_rdata)
  );

  eia_ram #(.Width(eia_pkg::RecBits + 1), .Depth(eia_pkg::Capacity)) u_rec (
    .clk_i, .we_i(rs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(id_q), .rdata_o(rs_rdata)
  );

  always_comb begin
    stat_o.kind = in_range || kind_q == eia_pkg::K_ALLOC || kind_q > eia_pkg::K_READ
                ? eia_pkg::kind_e'(kind_q) : eia_pkg::K_NONE;
    stat_o.stack_empty = depth_q == '0;
    stat_o.hw_full = hw_q >= eia_pkg::CntBits'(eia_pkg::Capacity);
    stat_o.scan_end = idx_q >= depth_q;
    stat_o.scan_hit = fs_rdata == id_q;
    stat_o.shift_end = idx_q + 1'b1 >= depth_q;
    stat_o.is_live = lv_rdata;
    stat_o.clear_end = idx_q == eia_pkg::CntBits'(eia_pkg::Capacity - 1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= kind_i;
      id_q <= ident_i;
      val_q <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= '0;
      depth_q <= '0;
      idx_q <= '0;
      rid_q <= '0;
      rec_q <= '0;
      st_q <= eia_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) idx_q <= idx_q + 1'b1;
      if (cmd_i.latch) begin
        idx_q <= '0;
        rid_q <= '0;
        rec_q <= '0;
        st_q <= eia_pkg::ST_OK;
      end
      if (cmd_i.pop_rd) depth_q <= depth_m1;
      if (cmd_i.pop_take) rid_q <= fs_rdata;
      if (cmd_i.fresh_take) begin
        rid_q <= hw_q[eia_pkg::IdBits-1:0];
        hw_q <= hw_q + 1'b1;
      end
      if (cmd_i.set_full) st_q <= eia_pkg::ST_FULL;
      if (cmd_i.set_ignored) st_q <= eia_pkg::ST_IGNORED;
      if (cmd_i.scan_next && !stat_o.scan_hit) idx_q <= idx_q + 1'b1;
      if (cmd_i.shift_rd && stat_o.shift_end) depth_q <= depth_m1;
      if (cmd_i.shift_wr) idx_q <= idx_q + 1'b1;
      if (cmd_i.claim) begin
        rid_q <= id_q;
        if (hw_q < id_ext + 1'b1) hw_q <= id_ext + 1'b1;
      end
      if (cmd_i.release_do) begin
        if (depth_q < eia_pkg::CntBits'(eia_pkg::Capacity)) depth_q <= depth_q + 1'b1;
      end
      if (cmd_i.rec_take) begin
        if (rs_rdata[eia_pkg::RecBits]) rec_q <= rs_rdata[eia_pkg::RecBits-1:0];
        else st_q <= eia_pkg::ST_NOTFOUND;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        if (!in_range && kind_q != eia_pkg::K_ALLOC && kind_q <= eia_pkg::K_READ) begin
          st_q <= eia_pkg::ST_RANGE;
          rid_q <= '0;
          rec_q <= '0;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_id_o = rid_q;
  assign status_o = st_q;
  assign record_value_o = rec_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= eia_pkg::CntBits'(eia_pkg::Capacity)) else $error("depth overflow");
  a_hw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= eia_pkg::CntBits'(eia_pkg::Capacity)) else $error("high water overflow");
  a_fresh_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fresh_take |-> !stat_o.hw_full && stat_o.stack_empty) else $error("bad fresh");
endmodule

// ----- src/entity_id_allocator.sv -----
`timescale 1ns / 1ps
// identifier allocator with lifo free stack, live marks and record table
// in_i sink channel carries one operation word: kind, ident, slot_index
// out_o source channel returns one result word per operation
// a word is taken on a rising edge with valid and ready both high
// release, bind, fresh allocate, full and unknown kinds pass from decode
// to the result load; pop and read first take a memory read and a wait state
// allocate-at scans the free stack one entry at a time, in a read and a check
// state, and on a hit shifts the tail down one entry at a time, in a read and
// a write state; the free stack memory with a single port pair sets this pace
// one operation in flight; the next word is taken the cycle after the result
// leaves the output register
// reset clears high water and stack depth, then a pass over all 1024 entries
// clears the live marks and record table with ready held low
// a stalled receiver holds the result and blocks the next word
module entity_id_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  eia_in_if.sink     in_i,
  eia_out_if.source  out_o
);
  eia_pkg::cmd_t  cmd;
  eia_pkg::stat_t stat;

  eia_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .out_valid_i(out_o.valid), .stat_i(stat), .cmd_o(cmd)
  );

  eia_datapath u_dp (
    .clk_i, .rst_ni, .kind_i(in_i.kind), .ident_i(in_i.ident),
    .slot_index_i(in_i.slot_index), .cmd_i(cmd), .stat_o(stat),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .result_id_o(out_o.result_id), .status_o(out_o.status),
    .record_value_o(out_o.record_value)
  );
endmodule
